// ----- rtl/core/ssp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sequential stream prefetcher.
// No dependencies; every other file of the block refers to it by scoped names.
package ssp_pkg;

    // Fixed field widths
    localparam int CNT_W  = 5;   // prefetch_count register and beat counters
    localparam int THR_W  = 8;   // thread identifier
    localparam int LS_W   = 6;   // line_shift register
    localparam int WIDE_W = 64;  // width of the set-index sum used for stream detection

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration register indexes
    localparam logic [1:0] REG_LINE_SHIFT = 2'd0;
    localparam logic [1:0] REG_SET_MASK   = 2'd1;
    localparam logic [1:0] REG_TAG_MASK   = 2'd2;
    localparam logic [1:0] REG_PF_COUNT   = 2'd3;

    // Configuration reset values
    localparam logic [LS_W-1:0]   LINE_SHIFT_RST = 6'd6;
    localparam logic [WIDE_W-1:0] SET_MASK_RST   = 64'h0000_0000_0000_FFC0;
    localparam logic [WIDE_W-1:0] TAG_MASK_RST   = 64'h0000_FFFF_FFFF_0000;
    localparam logic [CNT_W-1:0]  PF_COUNT_RST   = 5'd1;

    // Event kinds
    localparam logic ACT_MISS = 1'b0;
    localparam logic ACT_HIT  = 1'b1;

    // Queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ----- rtl/core/ssp_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts access events, detects streams and pointer hits,
// keeps last-miss and expected-prefetch state, pushes burst commands. Uses ssp_pkg.
module ssp_front #(
    parameter int ADDR_BITS = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_action,
    input  logic [ADDR_BITS-1:0]        i_address,
    input  logic [ssp_pkg::THR_W-1:0]   i_thread,
    input  logic [ssp_pkg::LS_W-1:0]    i_line_shift,
    input  logic [ADDR_BITS-1:0]        i_set_mask,
    input  logic [ADDR_BITS-1:0]        i_tag_mask,
    input  logic [ssp_pkg::CNT_W-1:0]   i_eff_count,
    input  logic [ADDR_BITS-1:0]        i_step,
    input  ssp_pkg::t_qstat             i_qstat,
    output logic                        o_push,
    output logic [ADDR_BITS-1:0]        o_first,
    output logic [ssp_pkg::CNT_W-1:0]   o_beats,
    output logic [ssp_pkg::THR_W-1:0]   o_thread
);
    localparam int CNT_W  = ssp_pkg::CNT_W;
    localparam int WIDE_W = ssp_pkg::WIDE_W;

    logic [ADDR_BITS-1:0] r_last_miss, n_last_miss;
    logic [ADDR_BITS-1:0] r_expected, n_expected;

    logic                 accept;
    logic [ADDR_BITS-1:0] set_in, set_last, set_exp;
    logic [ADDR_BITS-1:0] tag_in, tag_last, tag_exp;
    logic [ADDR_BITS-1:0] far_step;
    logic                 is_stream, is_hit;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    assign tag_in   = i_address   & i_tag_mask;
    assign tag_last = r_last_miss & i_tag_mask;
    assign tag_exp  = r_expected  & i_tag_mask;
    // shifts past the address width leave zero, as the set index wants
    assign set_in   = (i_address   & i_set_mask) >> i_line_shift;
    assign set_last = (r_last_miss & i_set_mask) >> i_line_shift;
    assign set_exp  = (r_expected  & i_set_mask) >> i_line_shift;

    // count lines ahead; step is a power of two, so this is a shift
    assign far_step = ADDR_BITS'(i_eff_count) << i_line_shift;

    assign is_stream = (i_action == ssp_pkg::ACT_MISS) && (tag_in == tag_last) &&
                       ((WIDE_W'(set_last) + WIDE_W'(1)) == WIDE_W'(set_in));
    assign is_hit    = (i_action == ssp_pkg::ACT_HIT) && (tag_in == tag_exp) &&
                       (set_in == set_exp);

    always_comb begin
        n_last_miss = r_last_miss;
        n_expected  = r_expected;
        o_push      = 1'b0;
        o_first     = i_address + i_step;
        o_beats     = i_eff_count;
        o_thread    = i_thread;
        if (accept) begin
            if (i_action == ssp_pkg::ACT_MISS) begin
                n_last_miss = i_address;
                if (is_stream) begin
                    n_expected = i_address + i_step;
                    o_push     = (i_eff_count != '0);
                end
            end else if (is_hit) begin
                n_expected = r_expected + i_step;
                o_push     = 1'b1;
                o_first    = i_address + far_step;
                o_beats    = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_miss <= '0;
            r_expected  <= '0;
        end else begin
            r_last_miss <= n_last_miss;
            r_expected  <= n_expected;
        end
    end

endmodule

// ----- rtl/core/ssp_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Register-based FIFO of depth ssp_pkg::QDEPTH; uses ssp_pkg.
module ssp_queue #(
    parameter int WIDTH = 61
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output ssp_pkg::t_qstat  o_stat
);
    localparam int QDEPTH = ssp_pkg::QDEPTH;
    localparam int QPTR_W = ssp_pkg::QPTR_W;

    logic [WIDTH-1:0]  r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/ssp_back.sv -----
`timescale 1ns / 1ps
// Back end: takes burst commands from the queue and issues one prefetch
// beat per cycle from its output register while the receiver does not stall. Uses ssp_pkg.
module ssp_back #(
    parameter int ADDR_BITS = 48
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ssp_pkg::t_qstat           i_qstat,
    input  logic [ADDR_BITS-1:0]      i_first,
    input  logic [ssp_pkg::CNT_W-1:0] i_beats,
    input  logic [ssp_pkg::THR_W-1:0] i_thread,
    input  logic [ADDR_BITS-1:0]      i_step,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ADDR_BITS-1:0]      o_prefetch_address,
    output logic [ssp_pkg::THR_W-1:0] o_thread_res,
    output logic                      o_last
);
    localparam int CNT_W = ssp_pkg::CNT_W;

    logic                      r_busy;
    logic [ADDR_BITS-1:0]      r_addr;
    logic [CNT_W-1:0]          r_left;
    logic [ssp_pkg::THR_W-1:0] r_thread;
    logic                      beat_done, final_beat;

    assign final_beat = (r_left == CNT_W'(1));
    assign beat_done  = r_busy && !i_stall;
    assign o_pop      = !i_qstat.empty && (!r_busy || (beat_done && final_beat));

    assign o_valid            = r_busy;
    assign o_prefetch_address = r_addr;
    assign o_thread_res       = r_thread;
    assign o_last             = final_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_left <= i_beats;
        end else if (beat_done) begin
            r_busy <= !final_beat;
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr   <= i_first;
            r_thread <= i_thread;
        end else if (beat_done) begin
            r_addr <= r_addr + i_step;
        end
    end

endmodule

// ----- rtl/core/sequential_stream_prefetch.sv -----
`timescale 1ns / 1ps
// Sequential stream prefetcher, top level: configuration registers, front end,
// command queue and back end. Uses ssp_pkg, ssp_front, ssp_queue, ssp_back.
//
// Usage:
//  - Input channel (i_valid / o_stall): one cache access event per beat, a miss
//    or a hit with its address and thread. A beat is taken every cycle while
//    the four-entry command queue has room; o_stall is simply "queue full".
//  - Output channel (o_valid / i_stall): one prefetch read address per beat,
//    o_last marks the final beat caused by an event.
//  - A stream miss yields prefetch_count beats (at most MAX_PREFETCH), a hit on the
//    expected-prefetch pointer yields one, anything else yields none.
//  - The first beat of an event passes the command queue and then the back end's
//    output register. The back end issues one beat per cycle while the receiver
//    does not stall and finishes one burst before it takes the next; the input keeps
//    flowing until the queue fills behind a long burst.
//  - When the receiver stalls, the current beat holds in the back end's output
//    register; the queue keeps absorbing events until full.
//  - Reset (synchronous, active low) clears both address trackers, the queue
//    and the back end, and restores configuration defaults. No clearing pass.
//  - Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//    the block is idle.
module sequential_stream_prefetch #(
    parameter int ADDR_BITS    = 48,
    parameter int MAX_PREFETCH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [ADDR_BITS-1:0]      i_cfg_data,
    // access events
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  logic [ADDR_BITS-1:0]      i_address,
    input  logic [ssp_pkg::THR_W-1:0] i_thread,
    // prefetch requests
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ADDR_BITS-1:0]      o_prefetch_address,
    output logic [ssp_pkg::THR_W-1:0] o_thread_res,
    output logic                      o_last
);
    localparam int CNT_W = ssp_pkg::CNT_W;
    localparam int THR_W = ssp_pkg::THR_W;
    localparam int LS_W  = ssp_pkg::LS_W;
    localparam int ENT_W = ADDR_BITS + CNT_W + THR_W;

    // configuration registers
    logic [LS_W-1:0]      r_line_shift;
    logic [ADDR_BITS-1:0] r_set_mask;
    logic [ADDR_BITS-1:0] r_tag_mask;
    logic [CNT_W-1:0]     r_pf_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_shift <= ssp_pkg::LINE_SHIFT_RST;
            r_set_mask   <= ssp_pkg::SET_MASK_RST[ADDR_BITS-1:0];
            r_tag_mask   <= ssp_pkg::TAG_MASK_RST[ADDR_BITS-1:0];
            r_pf_count   <= ssp_pkg::PF_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssp_pkg::REG_LINE_SHIFT: r_line_shift <= i_cfg_data[LS_W-1:0];
                ssp_pkg::REG_SET_MASK:   r_set_mask   <= i_cfg_data;
                ssp_pkg::REG_TAG_MASK:   r_tag_mask   <= i_cfg_data;
                ssp_pkg::REG_PF_COUNT:   r_pf_count   <= i_cfg_data[CNT_W-1:0];
                default:                 r_pf_count   <= r_pf_count;
            endcase
        end
    end

    // derived settings: one line step (zero once the shift passes the width)
    // and the count clamped to the burst limit
    logic [ADDR_BITS-1:0] step;
    logic [CNT_W-1:0]     eff_count;

    assign step      = ADDR_BITS'(1) << r_line_shift;
    assign eff_count = (int'(r_pf_count) > MAX_PREFETCH) ? CNT_W'(MAX_PREFETCH)
                                                         : r_pf_count;

    // front end -> queue -> back end
    ssp_pkg::t_qstat      q_stat;
    logic                 q_push, q_pop;
    logic [ADDR_BITS-1:0] f_first;
    logic [CNT_W-1:0]     f_beats;
    logic [THR_W-1:0]     f_thread;
    logic [ENT_W-1:0]     q_head;

    ssp_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_thread     (i_thread),
        .i_line_shift (r_line_shift),
        .i_set_mask   (r_set_mask),
        .i_tag_mask   (r_tag_mask),
        .i_eff_count  (eff_count),
        .i_step       (step),
        .i_qstat      (q_stat),
        .o_push       (q_push),
        .o_first      (f_first),
        .o_beats      (f_beats),
        .o_thread     (f_thread)
    );

    ssp_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_first, f_beats, f_thread}),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_stat  (q_stat)
    );

    ssp_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_qstat            (q_stat),
        .i_first            (q_head[ENT_W-1 -: ADDR_BITS]),
        .i_beats            (q_head[THR_W +: CNT_W]),
        .i_thread           (q_head[THR_W-1:0]),
        .i_step             (step),
        .o_pop              (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_prefetch_address (o_prefetch_address),
        .o_thread_res       (o_thread_res),
        .o_last             (o_last)
    );

    // checks
    a_push_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_pop_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    a_no_empty_burst : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_head[THR_W +: CNT_W] != '0))
        else $error("burst command with zero beats");

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && q_stat.empty))
        else $error("output or queue not idle after reset");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sequential_stream_prefetch.
// Depends on ssp_pkg and the block's RTL; carries its own model of the stream detector.
module testbench;

    localparam int AW     = 48;
    localparam int PF_MAX = 16;
    localparam int THR_W  = ssp_pkg::THR_W;
    localparam int LS_W   = ssp_pkg::LS_W;
    localparam int CNT_W  = ssp_pkg::CNT_W;

    typedef logic [AW-1:0] t_addr;

    // one prefetch read request as the block should issue it
    typedef struct {
        t_addr            addr;
        logic [THR_W-1:0] thr;
        logic             fin;
    } t_pf_req;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    t_addr             i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic              i_action;
    t_addr             i_address;
    logic [THR_W-1:0]  i_thread;
    logic              o_valid;
    logic              i_stall;
    t_addr             o_prefetch_address;
    logic [THR_W-1:0]  o_thread_res;
    logic              o_last;

    sequential_stream_prefetch #(
        .ADDR_BITS    (AW),
        .MAX_PREFETCH (PF_MAX)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_address          (i_address),
        .i_thread           (i_thread),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_prefetch_address (o_prefetch_address),
        .o_thread_res       (o_thread_res),
        .o_last             (o_last)
    );

    // Shadow copy of the configuration registers
    logic [LS_W-1:0]  cfg_shift;
    t_addr            cfg_set_mask;
    t_addr            cfg_tag_mask;
    logic [CNT_W-1:0] cfg_count;

    // Shadow copy of the two address trackers
    t_addr trk_last_miss;   // most recent miss
    t_addr trk_next_line;   // expected-prefetch pointer

    t_pf_req pf_due[$];     // requests predicted but not yet seen on the output
    t_pf_req head_req;

    int n_err      = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_settings = 0;
    int gap_pct    = 0;     // chance of a sender gap after each beat
    int stall_pct  = 0;     // chance of a receiver stall burst per free cycle

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop; generous against the worst case of 16 beats per event, each held by the longest stall
    initial begin
        #1_000_000;
        $error("timeout with %0d prefetch requests outstanding", pf_due.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model of the stream detector
    // ------------------------------------------------------------------
    function automatic t_addr set_of(t_addr a);
        // a shift of 48 or more on a 48-bit vector yields zero, as required
        return (a & cfg_set_mask) >> cfg_shift;
    endfunction

    function automatic t_addr tag_of(t_addr a);
        return a & cfg_tag_mask;
    endfunction

    function automatic t_addr line_step();
        return t_addr'(1) << cfg_shift;   // zero for shifts past the address width
    endfunction

    function automatic t_addr rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic predict_access(input logic act, input t_addr a, input logic [THR_W-1:0] thr);
        t_addr       step;
        t_addr       pa;
        logic [63:0] set_succ;
        int          n;
        step = line_step();
        n = (cfg_count > PF_MAX) ? PF_MAX : int'(cfg_count);
        if (act == ssp_pkg::ACT_MISS) begin
            // set index sum done at full width: no wrap from the top set to set zero
            set_succ = 64'(set_of(trk_last_miss)) + 64'd1;
            if (tag_of(a) == tag_of(trk_last_miss) && set_succ == 64'(set_of(a))) begin
                pa = a;
                for (int i = 1; i <= n; i++) begin
                    pa = pa + step;
                    pf_due.push_back('{pa, thr, i == n});
                end
                trk_next_line = a + step;
            end
            trk_last_miss = a;
        end else if (tag_of(a) == tag_of(trk_next_line) && set_of(a) == set_of(trk_next_line)) begin
            // count zero lands on the hit address itself
            pf_due.push_back('{a + step * t_addr'(n), thr, 1'b1});
            trk_next_line = trk_next_line + step;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one access beat, wait for it to be taken, then maybe idle.
    // Leaves i_valid high when no gap follows, so the next beat goes back to back.
    task automatic send_access(input logic act, input t_addr a, input logic [THR_W-1:0] thr);
        i_valid   <= 1'b1;
        i_action  <= act;
        i_address <= a;
        i_thread  <= thr;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        predict_access(act, a, thr);
        n_sent++;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Sender holds off until every predicted request has come out, then idles on
    // so the back end is surely idle before any register write.
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pf_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Writes all four registers on idle; upper data bits beyond a register are don't-care
    task automatic apply_setting(input t_addr shift_d, input t_addr set_d, input t_addr tag_d,
                                 input t_addr count_d);
        logic [1:0] idx_list[4];
        t_addr      data_list[4];
        idx_list  = '{ssp_pkg::REG_LINE_SHIFT, ssp_pkg::REG_SET_MASK, ssp_pkg::REG_TAG_MASK,
                      ssp_pkg::REG_PF_COUNT};
        data_list = '{shift_d, set_d, tag_d, count_d};
        wait_drain();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= data_list[k];
            @(posedge i_clk);
        end
        i_cfg_we     <= 1'b0;
        cfg_shift    = shift_d[LS_W-1:0];
        cfg_set_mask = set_d;
        cfg_tag_mask = tag_d;
        cfg_count    = count_d[CNT_W-1:0];
        n_settings++;
    endtask

    // Flavor 0 is plain random, 1 a count at or above the limit, 2 byte lines, 3 count zero,
    // 4 arbitrary masks
    task automatic random_setting(input int flavor);
        t_addr ones;
        t_addr junk;
        int    shift;
        int    k;
        int    cnt;
        t_addr setm;
        t_addr tagm;
        ones  = '1;
        shift = ($urandom_range(0, 9) == 0) ? $urandom_range(44, 63) : $urandom_range(0, 16);
        cnt   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
        case (flavor)
            1: cnt   = $urandom_range(16, 31);
            2: shift = 0;
            3: cnt   = 0;
            default: ;
        endcase
        k    = $urandom_range(1, 12);
        setm = (~(ones << k)) << shift;
        tagm = ones << (shift + k);
        if (flavor == 4) begin
            setm = rand_addr();
            tagm = rand_addr() & rand_addr();
        end
        // garbage above the narrow registers
        junk = rand_addr();
        apply_setting({junk[AW-1:LS_W], 6'(shift)}, setm, tagm,
                      $urandom_range(0, 1) ? {junk[AW-1:CNT_W], 5'(cnt)} : t_addr'(cnt));
    endtask

    // Mostly well-formed streams: sequential misses and hits on the pointer,
    // with random offsets inside the line; the rest is noise.
    task automatic random_access();
        t_addr step;
        t_addr lo;
        t_addr a;
        int    pick;
        step = line_step();
        lo   = (step == '0) ? '0 : (rand_addr() & (step - t_addr'(1)));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            a = ($urandom_range(0, 9) == 0) ? rand_addr() : trk_last_miss + step + lo;
            send_access(ssp_pkg::ACT_MISS, a, THR_W'($urandom));
        end else if (pick < 70) begin
            send_access(ssp_pkg::ACT_HIT, trk_next_line + lo, THR_W'($urandom));
        end else if (pick < 85) begin
            send_access(ssp_pkg::ACT_HIT, rand_addr(), THR_W'($urandom));
        end else begin
            send_access(ssp_pkg::ACT_MISS, rand_addr(), THR_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset configuration: stream from the reset state, hit inside a line,
    // stray hit, and a stream at the top of the address space that wraps.
    task automatic test_default_config();
        gap_pct   = 30;
        stall_pct = 20;
        send_access(ssp_pkg::ACT_MISS, 48'h0000_0000_0040, 8'hFF);
        send_access(ssp_pkg::ACT_HIT,  48'h0000_0000_00BF, 8'hA5);
        send_access(ssp_pkg::ACT_HIT,  48'h0000_0000_1000, 8'h01);
        send_access(ssp_pkg::ACT_MISS, 48'hFFFF_FFFF_FF80, 8'h00);
        send_access(ssp_pkg::ACT_MISS, 48'hFFFF_FFFF_FFC0, 8'h7E);
        send_access(ssp_pkg::ACT_HIT,  48'h0000_0000_0000, 8'h81);
    endtask

    // Count zero, the limit, and counts past it on both misses and hits
    task automatic test_count_limits();
        apply_setting(48'd6, 48'hFFC0, 48'hFFFF_FFFF_0000, 48'd0);
        send_access(ssp_pkg::ACT_MISS, 48'hABCD_0000_1000, 8'h10);
        send_access(ssp_pkg::ACT_MISS, 48'hABCD_0000_1040, 8'h11);
        send_access(ssp_pkg::ACT_HIT,  48'hABCD_0000_1080, 8'h12);
        apply_setting(48'd6, 48'hFFC0, 48'hFFFF_FFFF_0000, 48'd16);
        send_access(ssp_pkg::ACT_MISS, 48'hABCD_0000_1080, 8'h13);
        apply_setting(48'd6, 48'hFFC0, 48'hFFFF_FFFF_0000, 48'd31);
        send_access(ssp_pkg::ACT_MISS, 48'hABCD_0000_10C0, 8'h14);
        send_access(ssp_pkg::ACT_HIT,  48'hABCD_0000_1100, 8'h15);
        apply_setting(48'd6, 48'hFFC0, 48'hFFFF_FFFF_0000, 48'd17);
        send_access(ssp_pkg::ACT_HIT,  48'hABCD_0000_1150, 8'h16);
    endtask

    // Byte lines, the widest step (sums wrap), and shifts past the width (zero step)
    task automatic test_shift_extremes();
        apply_setting(48'd0, 48'hFF, 48'hFFFF_FFFF_FF00, 48'd3);
        send_access(ssp_pkg::ACT_MISS, 48'h0000_0000_5500, 8'hFF);
        send_access(ssp_pkg::ACT_MISS, 48'h0000_0000_5501, 8'hFF);
        apply_setting(48'd47, 48'h8000_0000_0000, 48'h0, 48'd3);
        send_access(ssp_pkg::ACT_MISS, 48'h0000_0000_0000, 8'h3C);
        send_access(ssp_pkg::ACT_MISS, 48'h8000_0000_0000, 8'hC3);
        apply_setting(48'd48, '1, 48'h0, 48'd2);
        send_access(ssp_pkg::ACT_HIT,  48'h1234_5678_9ABC, 8'h5A);
        send_access(ssp_pkg::ACT_MISS, 48'h0000_0000_0001, 8'hA5);
        apply_setting(48'd63, '1, '1, 48'd5);
        send_access(ssp_pkg::ACT_HIT,  48'h0000_0000_0000, 8'h00);
        send_access(ssp_pkg::ACT_MISS, 48'hFFFF_FFFF_FFFF, 8'hFF);
    endtask

    // Random phases, each with its own setting and idling mix; one phase without
    // idling, one where the sender waits mid-phase for all requests to drain.
    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            random_setting(p % 5);
            gap_pct   = (p == 2) ? 0 : $urandom_range(5, 40);
            stall_pct = (p == 2) ? 0 : $urandom_range(5, 40);
            for (int k = 0; k < 60; k++) begin
                if (p == 1 && k == 30) wait_drain();
                random_access();
            end
        end
    endtask

    // Last stretch at full rate on both sides
    task automatic test_back_to_back();
        apply_setting(48'd6, 48'hFFC0, 48'hFFFF_FFFF_0000, 48'd4);
        gap_pct   = 0;
        stall_pct = 0;
        for (int k = 0; k < 80; k++) random_access();
    endtask

    // ------------------------------------------------------------------
    // Receiver stall bursts
    // ------------------------------------------------------------------
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output check: every taken beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pf_due.size() == 0) begin
                $error("unexpected prefetch request, address %h", o_prefetch_address);
                n_err++;
            end else begin
                head_req = pf_due.pop_front();
                n_checked++;
                if (o_prefetch_address !== head_req.addr) begin
                    $error("prefetch_address: expected %h, got %h", head_req.addr,
                           o_prefetch_address);
                    n_err++;
                end
                if (o_thread_res !== head_req.thr) begin
                    $error("thread_res: expected %h, got %h", head_req.thr, o_thread_res);
                    n_err++;
                end
                if (o_last !== head_req.fin) begin
                    $error("last: expected %b, got %b", head_req.fin, o_last);
                    n_err++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= ssp_pkg::REG_LINE_SHIFT;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_action   <= ssp_pkg::ACT_MISS;
        i_address  <= '0;
        i_thread   <= '0;
        // model starts from the reset values
        cfg_shift     = ssp_pkg::LINE_SHIFT_RST;
        cfg_set_mask  = ssp_pkg::SET_MASK_RST[AW-1:0];
        cfg_tag_mask  = ssp_pkg::TAG_MASK_RST[AW-1:0];
        cfg_count     = ssp_pkg::PF_COUNT_RST;
        trk_last_miss = '0;
        trk_next_line = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_config();
        test_count_limits();
        test_shift_extremes();
        test_random_phases();
        test_back_to_back();

        wait_drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d access events under %0d register settings beyond reset;",
                 n_sent, n_settings);
        $display("%0d prefetch requests compared, %0d mismatches.", n_checked, n_err);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
